// ===== rtl/core/shep_pkg.sv =====
`timescale 1ns / 1ps

package shep_pkg;

  // default queue depth per channel
  localparam int unsigned QUEUE_DEPTH = 4;
  // longest accepted payload in octets
  localparam int unsigned MAX_FRAME_LEN = 256;

  localparam logic [31:0] EVENT_INTERVAL_RESET = 32'd0;
  localparam logic [15:0] TS_TOLERANCE_RESET = 16'd100;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic [0:0] {
    CFG_EVENT_INTERVAL = 1'b0,
    CFG_TS_TOLERANCE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_EMIT     = 2'd1,
    ACT_OVERFLOW = 2'd2,
    ACT_REJECT   = 2'd3
  } action_e;

  typedef struct packed {
    logic [31:0] stamp;
    logic        stamped;
    logic        src_ok;
    logic [15:0] seq;
    logic [9:0]  len;
    logic [15:0] tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    action_e     action;
    logic        overflowed;
    logic [31:0] event_stamp;
    logic        left_valid;
    logic [9:0]  left_len;
    logic [15:0] left_tag;
    logic [15:0] left_seq;
    logic        right_valid;
    logic [9:0]  right_len;
    logic [15:0] right_tag;
    logic [15:0] right_seq;
  } result_t;

  typedef struct packed {
    logic left;
    logic right;
  } pop_t;

endpackage

// ===== rtl/core/shep_ram.sv =====
`timescale 1ns / 1ps

module shep_ram #(
  parameter int unsigned WIDTH = shep_pkg::ENTRY_W,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ===== rtl/core/shep_resolve.sv =====
`timescale 1ns / 1ps

module shep_resolve (
  input  shep_pkg::entry_t  head_l_i,
  input  shep_pkg::entry_t  head_r_i,
  input  logic [15:0]       tol_i,
  input  logic              reject_i,
  input  logic              dropped_i,
  input  logic              pair_i,
  output shep_pkg::result_t res_o,
  output shep_pkg::pop_t    pop_o
);

  logic [31:0] diff;
  logic [31:0] tol_w;
  logic        same_ev;
  logic        l_newer;
  logic        lc;
  logic        rc;
  logic        lv;
  logic        rv;
  logic [31:0] ev;
  shep_pkg::pop_t pop;

  assign diff    = head_l_i.stamp - head_r_i.stamp;
  assign tol_w   = {16'd0, tol_i};
  // wrap-safe window around zero distance
  assign same_ev = (diff <= tol_w) || (diff >= ~tol_w);
  assign l_newer = (diff > tol_w) && (diff < shep_pkg::HALF_RANGE);

  always_comb begin
    lc = 1'b0;
    rc = 1'b0;
    pop = '{left: 1'b1, right: 1'b1};
    ev = 32'd0;
    if (head_l_i.stamped && head_r_i.stamped) begin
      if (same_ev) begin
        lc = 1'b1;
        rc = 1'b1;
        ev = head_l_i.stamp;
      end else if (l_newer) begin
        rc = 1'b1;
        pop.left = 1'b0;
        ev = head_r_i.stamp;
      end else begin
        lc = 1'b1;
        pop.right = 1'b0;
        ev = head_l_i.stamp;
      end
    end else if (head_l_i.stamped) begin
      lc = 1'b1;
      ev = head_l_i.stamp;
    end else if (head_r_i.stamped) begin
      rc = 1'b1;
      ev = head_r_i.stamp;
    end
  end

  assign lv = lc && head_l_i.src_ok && (head_l_i.len != 10'd0);
  assign rv = rc && head_r_i.src_ok && (head_r_i.len != 10'd0);

  always_comb begin
    res_o = '0;
    pop_o = '0;
    if (reject_i) begin
      res_o.action = shep_pkg::ACT_REJECT;
    end else if (!pair_i) begin
      res_o.action = dropped_i ? shep_pkg::ACT_OVERFLOW : shep_pkg::ACT_NONE;
      res_o.overflowed = dropped_i;
    end else begin
      pop_o             = pop;
      res_o.action      = shep_pkg::ACT_EMIT;
      res_o.overflowed  = dropped_i;
      res_o.event_stamp = ev;
      res_o.left_valid  = lv;
      res_o.left_len    = lv ? head_l_i.len : 10'd0;
      res_o.left_tag    = lv ? head_l_i.tag : 16'd0;
      res_o.left_seq    = head_l_i.seq;
      res_o.right_valid = rv;
      res_o.right_len   = rv ? head_r_i.len : 10'd0;
      res_o.right_tag   = rv ? head_r_i.tag : 16'd0;
      res_o.right_seq   = head_r_i.seq;
    end
  end

endmodule

// ===== rtl/core/stereo_half_event_pairer.sv =====
`timescale 1ns / 1ps

// channel   | signals                                        | dir
// ----------+------------------------------------------------+-----
// input     | in_valid_i / in_ready_o, half descriptor       | in
// result    | out_valid_o / out_ready_i, event fields        | out
// config    | cfg_we_i, cfg_idx_i, cfg_data_i (write only)   | in
//
// each transaction: the accept cycle enqueues the half and reads both channel
// heads from the entry ram, then the resolve stage resolves the event and pops
// the heads; the ram read-then-pop loop holds off the next half until that stage retires.
// reset empties the queues through head and count, no clearing pass.
// a waiting result sits in the output register while the next half is taken;
// a result that stays untaken holds the resolve stage once the next half is in it.

module stereo_half_event_pairer #(
  parameter int unsigned QUEUE_DEPTH = shep_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // half descriptors
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        channel_i,
  input  logic [9:0]  frame_len_i,
  input  logic [15:0] frame_tag_i,
  input  logic        source_valid_i,
  input  logic        has_stamp_i,
  input  logic [31:0] stamp_i,
  input  logic [15:0] sequence_req_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic        overflowed_o,
  output logic [31:0] event_stamp_o,
  output logic        left_valid_o,
  output logic [9:0]  left_len_o,
  output logic [15:0] left_tag_o,
  output logic [15:0] left_seq_o,
  output logic        right_valid_o,
  output logic [9:0]  right_len_o,
  output logic [15:0] right_tag_o,
  output logic [15:0] right_seq_o
);

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = QW + 1;
  localparam int unsigned RAM_DEPTH = 2 ** AW;
  localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);
  localparam logic [QW:0] QD_S = (QW + 1)'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);
  localparam logic [9:0] MAX_LEN = 10'(shep_pkg::MAX_FRAME_LEN);

  function automatic logic [QW-1:0] next_idx(input logic [QW-1:0] idx);
    return (idx == QLAST) ? '0 : idx + 1'b1;
  endfunction

  // queue pointers and stamp prediction, per channel
  logic [QW-1:0] head_q [2];
  logic [QW-1:0] head_d [2];
  logic [CW-1:0] count_q [2];
  logic [CW-1:0] count_d [2];
  logic [31:0]   last_q [2];
  logic [31:0]   last_d [2];
  logic          known_q [2];
  logic          known_d [2];

  logic [31:0] interval_q;
  logic [15:0] tol_q;

  // resolve stage
  logic             s1_valid_q;
  logic             s1_reject_q;
  logic             s1_dropped_q;
  logic             s1_pair_q;
  logic             s1_fwd_l_q;
  logic             s1_fwd_r_q;
  shep_pkg::entry_t s1_new_q;

  // output register
  logic              out_valid_q;
  shep_pkg::result_t out_q;

  logic in_acc;
  logic oversize;
  logic enq;
  logic s1_go;

  // enqueue path
  logic             full;
  logic [QW-1:0]    head_after;
  logic [CW-1:0]    count_base;
  logic [QW:0]      slot_sum;
  logic [QW-1:0]    slot;
  logic [CW-1:0]    cnt_n [2];
  logic [QW-1:0]    hd_n [2];
  logic             pair;
  logic             fwd;
  logic [31:0]      pred_stamp;
  shep_pkg::entry_t new_entry;

  shep_pkg::entry_t  rd_l;
  shep_pkg::entry_t  rd_r;
  shep_pkg::entry_t  head_l;
  shep_pkg::entry_t  head_r;
  shep_pkg::result_t res;
  shep_pkg::pop_t    pop;

  assign in_ready_o = !s1_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign oversize   = frame_len_i > MAX_LEN;
  assign enq        = in_acc && !oversize;
  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);

  // slot for the new half, after a possible drop of the oldest one
  always_comb begin
    full       = count_q[channel_i] == QD_C;
    head_after = full ? next_idx(head_q[channel_i]) : head_q[channel_i];
    count_base = full ? QD_C - 1'b1 : count_q[channel_i];
    slot_sum   = {1'b0, head_after} + {1'b0, count_base[QW-1:0]};
    slot       = (slot_sum >= QD_S) ? QW'(slot_sum - QD_S) : slot_sum[QW-1:0];
    // the new half is the head when its queue was empty after the drop
    fwd        = count_base == '0;
    cnt_n[0]   = count_q[0];
    cnt_n[1]   = count_q[1];
    hd_n[0]    = head_q[0];
    hd_n[1]    = head_q[1];
    cnt_n[channel_i] = count_base + 1'b1;
    hd_n[channel_i]  = head_after;
    pair       = (cnt_n[0] != '0) && (cnt_n[1] != '0);
  end

  // a missing stamp is predicted from the last one, or left as a sentinel
  assign pred_stamp = last_q[channel_i] + interval_q;

  always_comb begin
    new_entry.stamped = has_stamp_i || known_q[channel_i];
    new_entry.stamp   = has_stamp_i ? stamp_i :
                        (known_q[channel_i] ? pred_stamp : 32'd0);
    new_entry.src_ok  = source_valid_i;
    new_entry.seq     = sequence_req_i;
    new_entry.len     = frame_len_i;
    new_entry.tag     = frame_tag_i;
  end

  shep_ram #(
    .WIDTH(shep_pkg::ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (enq),
    .waddr_i  ({channel_i, slot}),
    .wdata_i  (new_entry),
    .re_i     (in_acc),
    .raddr_a_i({1'b0, hd_n[0]}),
    .raddr_b_i({1'b1, hd_n[1]}),
    .rdata_a_o(rd_l),
    .rdata_b_o(rd_r)
  );

  // the slot written in the accept cycle reads stale, so take it from s1
  assign head_l = s1_fwd_l_q ? s1_new_q : rd_l;
  assign head_r = s1_fwd_r_q ? s1_new_q : rd_r;

  shep_resolve u_resolve (
    .head_l_i (head_l),
    .head_r_i (head_r),
    .tol_i    (tol_q),
    .reject_i (s1_reject_q),
    .dropped_i(s1_dropped_q),
    .pair_i   (s1_pair_q),
    .res_o    (res),
    .pop_o    (pop)
  );

  // pointer updates: enqueue in the accept cycle, pops when s1 retires;
  // the two never fall in the same cycle
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      head_d[c]  = head_q[c];
      count_d[c] = count_q[c];
      last_d[c]  = last_q[c];
      known_d[c] = known_q[c];
    end
    if (enq) begin
      head_d[channel_i]  = hd_n[channel_i];
      count_d[channel_i] = cnt_n[channel_i];
      if (new_entry.stamped) begin
        last_d[channel_i]  = new_entry.stamp;
        known_d[channel_i] = 1'b1;
      end
    end
    if (s1_go) begin
      if (pop.left) begin
        head_d[0]  = next_idx(head_q[0]);
        count_d[0] = count_q[0] - 1'b1;
      end
      if (pop.right) begin
        head_d[1]  = next_idx(head_q[1]);
        count_d[1] = count_q[1] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        head_q[c]  <= '0;
        count_q[c] <= '0;
        last_q[c]  <= '0;
        known_q[c] <= 1'b0;
      end
      interval_q  <= shep_pkg::EVENT_INTERVAL_RESET;
      tol_q       <= shep_pkg::TS_TOLERANCE_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int c = 0; c < 2; c++) begin
        head_q[c]  <= head_d[c];
        count_q[c] <= count_d[c];
        last_q[c]  <= last_d[c];
        known_q[c] <= known_d[c];
      end
      if (cfg_we_i) begin
        unique case (shep_pkg::cfg_idx_e'(cfg_idx_i))
          shep_pkg::CFG_EVENT_INTERVAL: interval_q <= cfg_data_i;
          shep_pkg::CFG_TS_TOLERANCE:   tol_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload of the resolve stage and the output register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_reject_q  <= oversize;
      s1_dropped_q <= full;
      s1_pair_q    <= pair;
      s1_fwd_l_q   <= fwd && !channel_i;
      s1_fwd_r_q   <= fwd && channel_i;
      s1_new_q     <= new_entry;
    end
    if (s1_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_q.action;
  assign overflowed_o  = out_q.overflowed;
  assign event_stamp_o = out_q.event_stamp;
  assign left_valid_o  = out_q.left_valid;
  assign left_len_o    = out_q.left_len;
  assign left_tag_o    = out_q.left_tag;
  assign left_seq_o    = out_q.left_seq;
  assign right_valid_o = out_q.right_valid;
  assign right_len_o   = out_q.right_len;
  assign right_tag_o   = out_q.right_tag;
  assign right_seq_o   = out_q.right_seq;

`ifndef ASSERT_OFF
  // queue fill never runs past the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[0] <= QD_C) && (count_q[1] <= QD_C))
    else $error("queue count above depth");

  // an oversize half leaves the queues untouched
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && oversize |=> (count_q[0] == $past(count_q[0])) &&
                          (count_q[1] == $past(count_q[1])))
    else $error("rejected half changed queue state");

  // an emitted event pops at least one head
  a_emit_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && (res.action == shep_pkg::ACT_EMIT) |-> (pop.left || pop.right))
    else $error("event emitted without pop");

  // a left pop lowers the left fill by one
  a_pop_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && pop.left |=> count_q[0] == $past(count_q[0]) - 1'b1)
    else $error("left pop did not decrement count");
`endif

endmodule

// ===== sim/stereo_pair_checker.sv =====
`timescale 1ns / 1ps

module stereo_pair_checker #(
  parameter int unsigned DEPTH = shep_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        channel_i,
  input  logic [9:0]  frame_len_i,
  input  logic [15:0] frame_tag_i,
  input  logic        source_valid_i,
  input  logic        has_stamp_i,
  input  logic [31:0] stamp_i,
  input  logic [15:0] sequence_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  action_i,
  input  logic        overflowed_i,
  input  logic [31:0] event_stamp_i,
  input  logic        left_valid_i,
  input  logic [9:0]  left_len_i,
  input  logic [15:0] left_tag_i,
  input  logic [15:0] left_seq_i,
  input  logic        right_valid_i,
  input  logic [9:0]  right_len_i,
  input  logic [15:0] right_tag_i,
  input  logic [15:0] right_seq_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  import shep_pkg::*;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef struct {
    logic [31:0] stamp;
    logic        stamped;
    logic        src_ok;
    logic [15:0] seq;
    logic [9:0]  len;
    logic [15:0] tag;
  } half_rec_t;

  half_rec_t   half_store [2][DEPTH];
  int unsigned head_ptr [2];
  int unsigned fill [2];
  logic [31:0] last_pos [2];
  logic        pos_known [2];
  logic [31:0] interval;
  logic [15:0] tolerance;
  result_t     expected_events [$];
  result_t     got;
  result_t     predicted;

  initial mismatch_count_o = 0;

  function automatic logic same_stamp(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d <= 32'(tolerance)) || (d >= 32'hFFFF_FFFF - 32'(tolerance));
  endfunction

  function automatic logic stamp_newer(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d > 32'(tolerance)) && (d < HALF_RANGE);
  endfunction

  task automatic drop_head(input logic ch);
    head_ptr[ch] = (head_ptr[ch] + 1) % DEPTH;
    fill[ch] = fill[ch] - 1;
  endtask

  // concealed halves keep only the sequence number
  task automatic show_half(input half_rec_t h, input logic carries, output logic v,
                           output logic [9:0] len, output logic [15:0] tag,
                           output logic [15:0] seq);
    v   = carries && h.src_ok && (h.len != 10'd0);
    len = v ? h.len : 10'd0;
    tag = v ? h.tag : 16'd0;
    seq = h.seq;
  endtask

  task automatic pair_half(input logic ch, input logic [9:0] len, input logic [15:0] tag,
                           input logic src_ok, input logic has, input logic [31:0] stamp,
                           input logic [15:0] seq, output result_t res);
    int unsigned slot;
    logic        dropped;
    half_rec_t   lh;
    half_rec_t   rh;
    logic        show_l;
    logic        show_r;
    logic        pop_l;
    logic        pop_r;
    logic [31:0] ev;
    res = '0;
    dropped = 1'b0;
    if (len > MAX_FRAME_LEN) begin
      res.action = ACT_REJECT;
    end else begin
      if (fill[ch] >= DEPTH) begin
        drop_head(ch);
        dropped = 1'b1;
      end
      slot = (head_ptr[ch] + fill[ch]) % DEPTH;
      if (has) begin
        half_store[ch][slot].stamped = 1'b1;
        half_store[ch][slot].stamp = stamp;
        last_pos[ch] = stamp;
        pos_known[ch] = 1'b1;
      end else if (pos_known[ch]) begin
        half_store[ch][slot].stamped = 1'b1;
        half_store[ch][slot].stamp = last_pos[ch] + interval;
        last_pos[ch] = last_pos[ch] + interval;
      end else begin
        half_store[ch][slot].stamped = 1'b0;
        half_store[ch][slot].stamp = 32'd0;
      end
      half_store[ch][slot].src_ok = src_ok;
      half_store[ch][slot].seq = seq;
      half_store[ch][slot].len = len;
      half_store[ch][slot].tag = tag;
      fill[ch] = fill[ch] + 1;
      res.overflowed = dropped;
      if (fill[CH_LEFT] == 0 || fill[CH_RIGHT] == 0) begin
        res.action = dropped ? ACT_OVERFLOW : ACT_NONE;
      end else begin
        lh = half_store[CH_LEFT][head_ptr[CH_LEFT]];
        rh = half_store[CH_RIGHT][head_ptr[CH_RIGHT]];
        if (lh.stamped && rh.stamped) begin
          if (same_stamp(lh.stamp, rh.stamp)) begin
            show_l = 1'b1; show_r = 1'b1; pop_l = 1'b1; pop_r = 1'b1; ev = lh.stamp;
          end else if (stamp_newer(lh.stamp, rh.stamp)) begin
            show_l = 1'b0; show_r = 1'b1; pop_l = 1'b0; pop_r = 1'b1; ev = rh.stamp;
          end else begin
            show_l = 1'b1; show_r = 1'b0; pop_l = 1'b1; pop_r = 1'b0; ev = lh.stamp;
          end
        end else if (!lh.stamped && !rh.stamped) begin
          show_l = 1'b0; show_r = 1'b0; pop_l = 1'b1; pop_r = 1'b1; ev = 32'd0;
        end else if (lh.stamped) begin
          show_l = 1'b1; show_r = 1'b0; pop_l = 1'b1; pop_r = 1'b1; ev = lh.stamp;
        end else begin
          show_l = 1'b0; show_r = 1'b1; pop_l = 1'b1; pop_r = 1'b1; ev = rh.stamp;
        end
        res.action = ACT_EMIT;
        res.event_stamp = ev;
        show_half(lh, show_l, res.left_valid, res.left_len, res.left_tag, res.left_seq);
        show_half(rh, show_r, res.right_valid, res.right_len, res.right_tag, res.right_seq);
        if (pop_l) drop_head(CH_LEFT);
        if (pop_r) drop_head(CH_RIGHT);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] want);
    if (seen !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, seen, want));
    end
  endtask

  task automatic check_event(input result_t seen);
    result_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("result with no transaction outstanding");
    end else begin
      want = expected_events.pop_front();
      check_field("action", 32'(seen.action), 32'(want.action));
      check_field("overflowed", 32'(seen.overflowed), 32'(want.overflowed));
      check_field("event_stamp", seen.event_stamp, want.event_stamp);
      check_field("left_valid", 32'(seen.left_valid), 32'(want.left_valid));
      check_field("left_len", 32'(seen.left_len), 32'(want.left_len));
      check_field("left_tag", 32'(seen.left_tag), 32'(want.left_tag));
      check_field("left_seq", 32'(seen.left_seq), 32'(want.left_seq));
      check_field("right_valid", 32'(seen.right_valid), 32'(want.right_valid));
      check_field("right_len", 32'(seen.right_len), 32'(want.right_len));
      check_field("right_tag", 32'(seen.right_tag), 32'(want.right_tag));
      check_field("right_seq", 32'(seen.right_seq), 32'(want.right_seq));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        head_ptr[c] = 0;
        fill[c] = 0;
        last_pos[c] = 32'd0;
        pos_known[c] = 1'b0;
      end
      interval = EVENT_INTERVAL_RESET;
      tolerance = TS_TOLERANCE_RESET;
      expected_events.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.action = action_e'(action_i);
        got.overflowed = overflowed_i;
        got.event_stamp = event_stamp_i;
        got.left_valid = left_valid_i;
        got.left_len = left_len_i;
        got.left_tag = left_tag_i;
        got.left_seq = left_seq_i;
        got.right_valid = right_valid_i;
        got.right_len = right_len_i;
        got.right_tag = right_tag_i;
        got.right_seq = right_seq_i;
        check_event(got);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_EVENT_INTERVAL: interval = cfg_data_i;
          CFG_TS_TOLERANCE:   tolerance = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pair_half(channel_i, frame_len_i, frame_tag_i, source_valid_i, has_stamp_i,
                  stamp_i, sequence_req_i, predicted);
        expected_events.push_back(predicted);
      end
      pending_o = expected_events.size();
    end
  end

endmodule

// ===== sim/stereo_half_event_pairer_tb.sv =====
`timescale 1ns / 1ps

module stereo_half_event_pairer_tb;

  import shep_pkg::*;

  localparam logic        CH_LEFT      = 1'b0;
  localparam logic        CH_RIGHT     = 1'b1;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 100;
  // long receiver stall, well past what the output register and resolve stage absorb
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        channel_i;
  logic [9:0]  frame_len_i;
  logic [15:0] frame_tag_i;
  logic        source_valid_i;
  logic        has_stamp_i;
  logic [31:0] stamp_i;
  logic [15:0] sequence_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  action_o;
  logic        overflowed_o;
  logic [31:0] event_stamp_o;
  logic        left_valid_o;
  logic [9:0]  left_len_o;
  logic [15:0] left_tag_o;
  logic [15:0] left_seq_o;
  logic        right_valid_o;
  logic [9:0]  right_len_o;
  logic [15:0] right_tag_o;
  logic [15:0] right_seq_o;

  int          mismatch_count;
  int          pending;

  // idle odds in percent per cycle, changed between phases
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_req = 1'b0;

  // stimulus view of the current register values
  logic [31:0] cur_interval;
  logic [15:0] cur_tol;
  // nominal position of the next stereo event in the stream
  logic [31:0] stream_ts;
  logic [15:0] seq_ctr [2];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stereo_half_event_pairer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .channel_i      (channel_i),
    .frame_len_i    (frame_len_i),
    .frame_tag_i    (frame_tag_i),
    .source_valid_i (source_valid_i),
    .has_stamp_i    (has_stamp_i),
    .stamp_i        (stamp_i),
    .sequence_req_i (sequence_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .overflowed_o   (overflowed_o),
    .event_stamp_o  (event_stamp_o),
    .left_valid_o   (left_valid_o),
    .left_len_o     (left_len_o),
    .left_tag_o     (left_tag_o),
    .left_seq_o     (left_seq_o),
    .right_valid_o  (right_valid_o),
    .right_len_o    (right_len_o),
    .right_tag_o    (right_tag_o),
    .right_seq_o    (right_seq_o)
  );

  stereo_pair_checker #(
    .DEPTH (QUEUE_DEPTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .channel_i        (channel_i),
    .frame_len_i      (frame_len_i),
    .frame_tag_i      (frame_tag_i),
    .source_valid_i   (source_valid_i),
    .has_stamp_i      (has_stamp_i),
    .stamp_i          (stamp_i),
    .sequence_req_i   (sequence_req_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .action_i         (action_o),
    .overflowed_i     (overflowed_o),
    .event_stamp_i    (event_stamp_o),
    .left_valid_i     (left_valid_o),
    .left_len_i       (left_len_o),
    .left_tag_i       (left_tag_o),
    .left_seq_i       (left_seq_o),
    .right_valid_i    (right_valid_o),
    .right_len_i      (right_len_o),
    .right_tag_i      (right_tag_o),
    .right_seq_i      (right_seq_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ready_i = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one half; entered and left at a falling edge, valid stays high on return
  // so back-to-back transactions keep valid high in between unless an idle draw drops it
  task automatic send_half(input logic ch, input logic [9:0] len, input logic [15:0] tag,
                           input logic src, input logic has, input logic [31:0] stamp,
                           input logic [15:0] seq);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    channel_i      = ch;
    frame_len_i    = len;
    frame_tag_i    = tag;
    source_valid_i = src;
    has_stamp_i    = has;
    stamp_i        = stamp;
    sequence_req_i = seq;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // directed half with random tag and sequence number
  task automatic send_dir(input logic ch, input logic has, input logic [31:0] stamp,
                          input logic [9:0] len, input logic src);
    send_half(ch, len, 16'($urandom), src, has, stamp, 16'($urandom));
  endtask

  // sender stops and waits until every outstanding result has been taken
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic write_config(input logic [31:0] interval, input logic [15:0] tol);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_EVENT_INTERVAL;
    cfg_data_i = interval;
    @(negedge clk_i);
    cfg_idx_i  = CFG_TS_TOLERANCE;
    cfg_data_i = {16'($urandom_range(65535)), tol};
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cur_interval = interval;
    cur_tol      = tol;
  endtask

  // well-formed half near the stream position, jitter mostly inside the tolerance
  task automatic stream_half(input logic ch);
    logic [31:0] jit;
    logic [31:0] st;
    logic [9:0]  len;
    jit = ($urandom_range(99) < 80) ? $urandom_range(32'(cur_tol))
                                    : $urandom_range(4 * 32'(cur_tol) + 200);
    st  = $urandom_range(1) ? stream_ts + jit : stream_ts - jit;
    len = ($urandom_range(99) < 5) ? 10'd0 : 10'($urandom_range(MAX_FRAME_LEN, 1));
    send_half(ch, len, 16'($urandom), ($urandom_range(99) < 90),
              ($urandom_range(99) < 85), st, seq_ctr[ch]);
    seq_ctr[ch] = seq_ctr[ch] + 16'd1;
  endtask

  // fully random descriptor, or one that is sure to be oversized
  task automatic noise_half(input logic oversize);
    logic [9:0] len;
    len = oversize ? 10'($urandom_range(1023, MAX_FRAME_LEN + 1)) : 10'($urandom_range(1023));
    send_half(1'($urandom_range(1)), len, 16'($urandom), 1'($urandom_range(1)),
              1'($urandom_range(1)), $urandom, 16'($urandom));
  endtask

  task automatic run_directed();
    logic sc;
    logic oc;
    // positional sentinels exist only before a channel's first stamp, and the
    // mixed pairing can only go one way per reset, so the side is picked at random
    sc = 1'($urandom_range(1));
    oc = ~sc;
    send_dir(sc, 1'b0, 32'd0, 10'd40, 1'b1);     // lone sentinel, nothing to pair
    send_dir(oc, 1'b0, 32'd0, 10'd40, 1'b1);     // both sentinels
    send_dir(sc, 1'b0, 32'd0, 10'd40, 1'b1);
    send_dir(sc, 1'b0, 32'd0, 10'd40, 1'b1);
    send_dir(oc, 1'b1, 32'd1000, 10'd40, 1'b0);  // stamped against sentinel
    send_dir(oc, 1'b0, 32'd0, 10'd40, 1'b1);     // predicted with zero interval
    send_dir(sc, 1'b1, 32'd1050, 10'd40, 1'b1);
    send_dir(oc, 1'b0, 32'd0, 10'd40, 1'b1);     // same event within tolerance
    wait_drained();
    write_config(32'd1000, 16'd100);
    // left newer, right emitted alone; extremes of tag and sequence number
    send_half(CH_LEFT, MAX_FRAME_LEN[9:0], 16'hFFFF, 1'b1, 1'b1, 32'd5000, 16'hFFFF);
    send_half(CH_RIGHT, 10'd0, 16'h0000, 1'b1, 1'b1, 32'd3000, 16'h0000);
    send_dir(CH_RIGHT, 1'b0, 32'hDEAD_BEEF, 10'd7, 1'b1);  // predicted 4000
    send_dir(CH_RIGHT, 1'b1, 32'd5100, 10'd7, 1'b1);       // distance exactly tolerance
    // just outside the tolerance on the negative side, then realigned
    send_dir(CH_LEFT, 1'b1, 32'd7000, 10'd1, 1'b1);
    send_dir(CH_RIGHT, 1'b1, 32'd7102, 10'd1, 1'b1);
    send_dir(CH_LEFT, 1'b1, 32'd7202, 10'd1, 1'b1);
    // same event across the 2^32 wrap
    send_dir(CH_LEFT, 1'b1, 32'hFFFF_FFF0, 10'd99, 1'b1);
    send_dir(CH_RIGHT, 1'b1, 32'h0000_0010, 10'd99, 1'b1);
    // distance of exactly half the range
    send_dir(CH_LEFT, 1'b1, 32'h0000_1000, 10'd99, 1'b1);
    send_dir(CH_RIGHT, 1'b1, 32'h8000_1000, 10'd99, 1'b1);
    send_dir(CH_LEFT, 1'b1, 32'h8000_1000, 10'd99, 1'b0);
    // fill the left queue and push one more to drop the oldest
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      send_dir(CH_LEFT, 1'b1, 32'd20000 + 32'(i * 10), 10'd12, 1'b1);
    end
    send_dir(CH_RIGHT, 1'b1, 32'd20010, MAX_FRAME_LEN[9:0] + 10'd1, 1'b1);  // oversize
    send_dir(CH_RIGHT, 1'b1, 32'd20010, 10'd1023, 1'b1);                    // oversize
    send_dir(CH_RIGHT, 1'b1, 32'd20010, 10'd12, 1'b1);
  endtask

  // mostly paired traffic, with lost mates, bursts and raw noise mixed in
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned mode;
    int unsigned k;
    logic        ch;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(99);
      ch   = 1'($urandom_range(1));
      if (mode < 3) stream_ts = $urandom;
      if (mode < 55) begin
        stream_half(ch);
        stream_half(~ch);
        sent += 2;
      end else if (mode < 70) begin
        // mate of this half is lost
        stream_half(ch);
        sent += 1;
      end else if (mode < 80) begin
        // one channel runs ahead, which can overflow its queue
        k = $urandom_range(6, 3);
        repeat (k) begin
          stream_half(ch);
          stream_ts = stream_ts + cur_interval;
        end
        sent += k;
      end else begin
        noise_half(mode >= 90);
        sent += 1;
      end
      stream_ts = stream_ts + cur_interval;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_EVENT_INTERVAL;
    cfg_data_i     = 32'd0;
    in_valid_i     = 1'b0;
    channel_i      = CH_LEFT;
    frame_len_i    = 10'd0;
    frame_tag_i    = 16'd0;
    source_valid_i = 1'b0;
    has_stamp_i    = 1'b0;
    stamp_i        = 32'd0;
    sequence_req_i = 16'd0;
    tx_idle_pct    = 31;
    rx_idle_pct    = 76;
    cur_interval   = EVENT_INTERVAL_RESET;
    cur_tol        = TS_TOLERANCE_RESET;
    stream_ts      = $urandom;
    seq_ctr[0]     = 16'($urandom);
    seq_ctr[1]     = 16'($urandom);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      // first sender-light / receiver-heavy idling, then reversed, then none
      if (p < 2) begin
        tx_idle_pct = 31;
        rx_idle_pct = 76;
      end else if (p < 4) begin
        tx_idle_pct = 76;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0:       write_config(32'd1000, 16'd100);
        1:       write_config(32'hFFFF_FFFF, 16'd0);
        2:       write_config(32'd480, 16'hFFFF);
        3:       write_config(32'd0, 16'd50);
        4:       write_config($urandom, 16'($urandom));
        default: write_config(32'd960, 16'd200);
      endcase
      // receiver stalls long while the sender keeps offering
      if (p == 2 || p == 4) hold_req = 1'b1;
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== stereo_half_event_pairer.f =====
rtl/core/shep_pkg.sv
rtl/core/shep_ram.sv
rtl/core/shep_resolve.sv
rtl/core/stereo_half_event_pairer.sv
sim/stereo_pair_checker.sv
sim/stereo_half_event_pairer_tb.sv
